[design/assert_macros.svh]
// Assertion macros shared by the allocator RTL.
// No dependencies; the assertion bodies are compiled out under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// The consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

// The condition never holds
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_IMPLY(label, clk, rst, pre, post, msg)
`define ASSERT_NEXT(label, clk, rst, pre, post, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

[design/dbba_pkg.sv]
// Shared types, constants and helper functions of the block availability map allocator.
// No dependencies; used by the top level.
package dbba_pkg;

   // Disk geometry
   localparam int NUM_TRACKS      = 80;
   localparam int SECTORS_PER_TRK = 40;
   localparam int RESERVED_TRACK  = 40;

   // Field widths
   localparam int REQ_W   = 3;
   localparam int TRK_W   = 7;
   localparam int SEC_W   = 6;
   localparam int CNT_W   = 8;
   localparam int MAP_W   = 40;
   localparam int STAT_W  = 2;
   localparam int ENTRY_W = CNT_W + MAP_W;
   localparam int ADDR_W  = $clog2(NUM_TRACKS);
   localparam int SRCH_W  = $clog2(NUM_TRACKS + RESERVED_TRACK + 2);

   // Sectors that exist on a track
   localparam logic [MAP_W-1:0] SECTOR_MASK =
      MAP_W'((65'd1 << SECTORS_PER_TRK) - 65'd1);

   // First track visited by the nearest-block search
   localparam int START_TRACK = (RESERVED_TRACK - 1 > NUM_TRACKS) ? NUM_TRACKS :
                                (RESERVED_TRACK > 1) ? RESERVED_TRACK - 1 :
                                RESERVED_TRACK + 1;

   typedef enum logic [REQ_W-1:0] {
      REQ_LOAD      = 3'd0,
      REQ_NEAREST   = 3'd1,
      REQ_ALLOC_TRK = 3'd2,
      REQ_FREE      = 3'd3,
      REQ_READ      = 3'd4
   } req_type_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_NONE  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ONE,
      S_SRCH
   } state_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [MAP_W-1:0] map;
   } entry_type;

   typedef struct packed {
      logic             hit;
      logic [SEC_W-1:0] sec;
   } pick_type;

   // Lowest set bit of a free map
   function automatic pick_type find_first(input logic [MAP_W-1:0] map);
      pick_type p;
      p.hit = 1'b0;
      p.sec = '0;
      for (int i = MAP_W - 1; i >= 0; i--) begin
         if (map[i]) begin
            p.hit = 1'b1;
            p.sec = SEC_W'(i);
         end
      end
      return p;
   endfunction

   // Search order: below the reserved track going down, then above it going up
   function automatic logic [SRCH_W-1:0] next_track(input logic [SRCH_W-1:0] t);
      logic [SRCH_W-1:0] n;
      if (32'(t) < RESERVED_TRACK) begin
         if (32'(t) == 1) begin
            n = SRCH_W'(RESERVED_TRACK + 1);
         end else begin
            n = t - SRCH_W'(1);
         end
      end else begin
         n = t + SRCH_W'(1);
      end
      return n;
   endfunction

endpackage

[design/disk_block_bitmap_allocator.sv]
// Channel   Handshake          Payload
// request   start / busy       req_type, req_track_num, req_sector_num, req_count_in, req_map_in
// response  rsp_valid strobe   rsp_status, rsp_got_track, rsp_got_sector, rsp_count_out,
//                              rsp_map_out
//
// Load and range errors answer one cycle after the item is taken. Read, free and
// allocate-on-track take one track-map RAM read: the answer passes the RAM read
// register, then the response register. Nearest allocation reads one track entry per
// cycle through the RAM read port, up to 79 tracks. busy stays high until the answer is
// registered. Reset clears the per-track valid flags, so the map reads as empty at
// once; no clearing pass. The response strobe lasts one cycle and cannot be stalled.
//
// Top level of the block availability map allocator; uses dbba_pkg, dbba_ram and
// assert_macros.svh.
`include "assert_macros.svh"

module disk_block_bitmap_allocator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [dbba_pkg::REQ_W-1:0]  req_type,
   input  logic [dbba_pkg::TRK_W-1:0]  req_track_num,
   input  logic [dbba_pkg::SEC_W-1:0]  req_sector_num,
   input  logic [dbba_pkg::CNT_W-1:0]  req_count_in,
   input  logic [dbba_pkg::MAP_W-1:0]  req_map_in,
   output logic                        rsp_valid,
   output logic [dbba_pkg::STAT_W-1:0] rsp_status,
   output logic [dbba_pkg::TRK_W-1:0]  rsp_got_track,
   output logic [dbba_pkg::SEC_W-1:0]  rsp_got_sector,
   output logic [dbba_pkg::CNT_W-1:0]  rsp_count_out,
   output logic [dbba_pkg::MAP_W-1:0]  rsp_map_out
);
   import dbba_pkg::*;

   state_type         state_ff, state_in;
   req_type_type      rq_type_ff;
   logic [TRK_W-1:0]  rq_trk_ff;
   logic [SEC_W-1:0]  rq_sec_ff;
   logic [SRCH_W-1:0] srch_trk_ff, srch_trk_in;
   logic [NUM_TRACKS-1:0] valid_ff;
   logic              vld_q_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [TRK_W-1:0]  rsp_trk_ff, rsp_trk_in;
   logic [SEC_W-1:0]  rsp_sec_ff, rsp_sec_in;
   logic [CNT_W-1:0]  rsp_cnt_ff, rsp_cnt_in;
   logic [MAP_W-1:0]  rsp_map_ff, rsp_map_in;

   logic              ram_we, ram_re;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   entry_type         ram_wdata;
   logic [ENTRY_W-1:0] ram_rdata;

   logic              accept, trk_ok, sec_ok;
   entry_type         entry_q, taken, freed, loaded;
   pick_type          pick;
   logic              hit;
   logic [MAP_W-1:0]  free_bit;
   logic [SRCH_W-1:0] nxt_trk;
   logic              srch_end;

   dbba_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_TRACKS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Decode the incoming item
   assign accept = start && !busy;
   assign trk_ok = (req_track_num != '0) && (32'(req_track_num) <= NUM_TRACKS);
   assign sec_ok = 32'(req_sector_num) < SECTORS_PER_TRK;
   assign loaded = '{count: req_count_in, map: req_map_in & SECTOR_MASK};

   // Evaluate the entry that the RAM returns; a never-written track reads empty
   assign entry_q  = vld_q_ff ? entry_type'(ram_rdata) : '0;
   assign pick     = find_first(entry_q.map & SECTOR_MASK);
   assign hit      = (entry_q.count != '0) && pick.hit;
   assign taken    = '{count: entry_q.count - CNT_W'(1),
                       map:   entry_q.map & ~(MAP_W'(1) << pick.sec)};
   assign free_bit = MAP_W'(1) << rq_sec_ff;
   assign freed    = ((entry_q.map & free_bit) != '0) ? entry_q :
                     '{count: entry_q.count + CNT_W'(1), map: entry_q.map | free_bit};
   assign nxt_trk  = next_track(srch_trk_ff);
   assign srch_end = 32'(nxt_trk) > NUM_TRACKS;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_type_type'(req_type))
                  REQ_NEAREST: state_in = S_SRCH;
                  REQ_ALLOC_TRK, REQ_READ: begin
                     if (trk_ok) state_in = S_ONE;
                  end
                  REQ_FREE: begin
                     if (trk_ok && sec_ok) state_in = S_ONE;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_ONE: state_in = S_IDLE;
         S_SRCH: begin
            if (hit || srch_end) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // RAM control, search pointer and response values
   always_comb begin
      busy          = (state_ff != S_IDLE);
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = '0;
      ram_re        = 1'b0;
      ram_raddr     = '0;
      srch_trk_in   = srch_trk_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_RANGE;
      rsp_trk_in    = '0;
      rsp_sec_in    = '0;
      rsp_cnt_in    = '0;
      rsp_map_in    = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_type_type'(req_type))
                  REQ_LOAD: begin
                     rsp_valid_in = 1'b1;
                     if (trk_ok) begin
                        ram_we        = 1'b1;
                        ram_waddr     = ADDR_W'(req_track_num - TRK_W'(1));
                        ram_wdata     = loaded;
                        rsp_status_in = ST_OK;
                     end
                  end
                  REQ_NEAREST: begin
                     ram_re      = 1'b1;
                     ram_raddr   = ADDR_W'(START_TRACK - 1);
                     srch_trk_in = SRCH_W'(START_TRACK);
                  end
                  REQ_ALLOC_TRK, REQ_READ: begin
                     if (trk_ok) begin
                        ram_re    = 1'b1;
                        ram_raddr = ADDR_W'(req_track_num - TRK_W'(1));
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  REQ_FREE: begin
                     if (trk_ok && sec_ok) begin
                        ram_re    = 1'b1;
                        ram_raddr = ADDR_W'(req_track_num - TRK_W'(1));
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         S_ONE: begin
            rsp_valid_in = 1'b1;
            case (rq_type_ff)
               REQ_ALLOC_TRK: begin
                  if (hit) begin
                     ram_we        = 1'b1;
                     ram_waddr     = ADDR_W'(rq_trk_ff - TRK_W'(1));
                     ram_wdata     = taken;
                     rsp_status_in = ST_OK;
                     rsp_trk_in    = rq_trk_ff;
                     rsp_sec_in    = pick.sec;
                  end else begin
                     rsp_status_in = ST_NONE;
                  end
               end
               REQ_FREE: begin
                  ram_we        = 1'b1;
                  ram_waddr     = ADDR_W'(rq_trk_ff - TRK_W'(1));
                  ram_wdata     = freed;
                  rsp_status_in = ST_OK;
               end
               REQ_READ: begin
                  rsp_status_in = ST_OK;
                  rsp_cnt_in    = entry_q.count;
                  rsp_map_in    = entry_q.map;
               end
               default: rsp_status_in = ST_RANGE;
            endcase
         end
         S_SRCH: begin
            if (hit) begin
               ram_we        = 1'b1;
               ram_waddr     = ADDR_W'(srch_trk_ff - SRCH_W'(1));
               ram_wdata     = taken;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_trk_in    = TRK_W'(srch_trk_ff);
               rsp_sec_in    = pick.sec;
            end else if (srch_end) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_NONE;
            end else begin
               ram_re      = 1'b1;
               ram_raddr   = ADDR_W'(nxt_trk - SRCH_W'(1));
               srch_trk_in = nxt_trk;
            end
         end
         default: busy = 1'b1;
      endcase
   end

   // Control registers: state, valid flags, response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ram_we) begin
            valid_ff[ram_waddr] <= 1'b1;
         end
      end
   end

   // Hold the request, the search pointer and the read qualifier
   always_ff @(posedge clock) begin
      if (accept) begin
         rq_type_ff <= req_type_type'(req_type);
         rq_trk_ff  <= req_track_num;
         rq_sec_ff  <= req_sector_num;
      end
      srch_trk_ff <= srch_trk_in;
      if (ram_re) begin
         vld_q_ff <= valid_ff[ram_raddr];
      end
   end

   // Response payload, loaded with the strobe
   always_ff @(posedge clock) begin
      if (rsp_valid_in) begin
         rsp_status_ff <= rsp_status_in;
         rsp_trk_ff    <= rsp_trk_in;
         rsp_sec_ff    <= rsp_sec_in;
         rsp_cnt_ff    <= rsp_cnt_in;
         rsp_map_ff    <= rsp_map_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_got_track  = rsp_trk_ff;
   assign rsp_got_sector = rsp_sec_ff;
   assign rsp_count_out  = rsp_cnt_ff;
   assign rsp_map_out    = rsp_map_ff;

   // Checks
   `ASSERT_NEXT(a_accept_answers, clock, reset, accept, busy || rsp_valid, "item taken but neither busy nor answered")
   `ASSERT_IMPLY(a_strobe_idle, clock, reset, rsp_valid, !busy, "response strobe while busy")
   `ASSERT_IMPLY(a_none_no_track, clock, reset, rsp_valid && (rsp_status == ST_NONE), rsp_got_track == '0, "failed allocation reports a track")
   `ASSERT_IMPLY(a_srch_skips_dir, clock, reset, state_ff == S_SRCH, 32'(srch_trk_ff) != RESERVED_TRACK, "search visits the reserved track")
   `ASSERT_NEVER(a_no_rw_overlap, clock, reset, ram_we && ram_re && (ram_waddr == ram_raddr), "read and write of one entry in one cycle")

endmodule

[design/dbba_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module dbba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[tb/sv/tb_disk_block_bitmap_allocator.sv]
// Self-checking testbench of the block availability map allocator: directed and random items,
// predicted by a behavioral copy of the track map and compared field by field.
// Depends on dbba_pkg and the disk_block_bitmap_allocator top level.
`timescale 1ns / 1ps

module tb_disk_block_bitmap_allocator;
   import dbba_pkg::*;

   // One request item as queued for the driver
   typedef struct {
      logic [REQ_W-1:0] kind;
      logic [TRK_W-1:0] trk;
      logic [SEC_W-1:0] sec;
      logic [CNT_W-1:0] cnt;
      logic [MAP_W-1:0] map;
      bit               drain;
   } bam_req_t;

   // One answer of the block
   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [TRK_W-1:0]  trk;
      logic [SEC_W-1:0]  sec;
      logic [CNT_W-1:0]  cnt;
      logic [MAP_W-1:0]  map;
   } bam_rsp_t;

   localparam int RAND_ROUNDS    = 4;
   localparam int ROUND_ITEMS    = 150;
   localparam int TAIL_CYCLES    = 90;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [REQ_W-1:0]  req_type       = '0;
   logic [TRK_W-1:0]  req_track_num  = '0;
   logic [SEC_W-1:0]  req_sector_num = '0;
   logic [CNT_W-1:0]  req_count_in   = '0;
   logic [MAP_W-1:0]  req_map_in     = '0;
   logic              rsp_valid;
   logic [STAT_W-1:0] rsp_status;
   logic [TRK_W-1:0]  rsp_got_track;
   logic [SEC_W-1:0]  rsp_got_sector;
   logic [CNT_W-1:0]  rsp_count_out;
   logic [MAP_W-1:0]  rsp_map_out;

   // Predicted track entries, indexed by track number
   logic [MAP_W-1:0] trk_map [1:NUM_TRACKS] = '{default: '0};
   logic [CNT_W-1:0] trk_cnt [1:NUM_TRACKS] = '{default: '0};

   bam_req_t pending_reqs[$];
   bam_rsp_t expected_rsps[$];
   bam_req_t cur_req;
   int       err_cnt    = 0;
   int       gap_left   = 0;
   int       burst_left = 0;

   disk_block_bitmap_allocator uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_track_num  (req_track_num),
      .req_sector_num (req_sector_num),
      .req_count_in   (req_count_in),
      .req_map_in     (req_map_in),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_got_track  (rsp_got_track),
      .rsp_got_sector (rsp_got_sector),
      .rsp_count_out  (rsp_count_out),
      .rsp_map_out    (rsp_map_out)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit track_valid(logic [TRK_W-1:0] t);
      return t >= 1 && t <= NUM_TRACKS;
   endfunction

   // Lowest free sector of a track, -1 when the count is zero or the map is empty
   function automatic int lowest_free(int t);
      if (trk_cnt[t] == '0) return -1;
      for (int n = 0; n < SECTORS_PER_TRK; n++) begin
         if (trk_map[t][n]) return n;
      end
      return -1;
   endfunction

   // Claim a sector found by lowest_free and report it
   function automatic void take_sector(int t, int s, ref bam_rsp_t r);
      trk_map[t][s] = 1'b0;
      if (trk_cnt[t] != '0) trk_cnt[t] = trk_cnt[t] - 1'b1;
      r.status = ST_OK;
      r.trk    = TRK_W'(t);
      r.sec    = SEC_W'(s);
   endfunction

   // Advance the predicted map by one item and return its answer
   function automatic bam_rsp_t predict_alloc(bam_req_t it);
      bam_rsp_t r;
      int       s;
      int       t;
      bit       found;
      r      = '0;
      r.status = ST_RANGE;
      found  = 1'b0;
      case (it.kind)
         REQ_LOAD: begin
            if (track_valid(it.trk)) begin
               trk_map[it.trk] = it.map & SECTOR_MASK;
               trk_cnt[it.trk] = it.cnt;
               r.status = ST_OK;
            end
         end
         REQ_NEAREST: begin
            r.status = ST_NONE;
            // Search downward from below the reserved track, then upward above it
            for (t = RESERVED_TRACK - 1; t >= 1 && !found; t--) begin
               if (t <= NUM_TRACKS) begin
                  s = lowest_free(t);
                  if (s >= 0) begin
                     take_sector(t, s, r);
                     found = 1'b1;
                  end
               end
            end
            for (t = RESERVED_TRACK + 1; t <= NUM_TRACKS && !found; t++) begin
               s = lowest_free(t);
               if (s >= 0) begin
                  take_sector(t, s, r);
                  found = 1'b1;
               end
            end
         end
         REQ_ALLOC_TRK: begin
            if (track_valid(it.trk)) begin
               s = lowest_free(it.trk);
               if (s >= 0) take_sector(it.trk, s, r);
               else r.status = ST_NONE;
            end
         end
         REQ_FREE: begin
            if (track_valid(it.trk) && it.sec < SECTORS_PER_TRK) begin
               if (!trk_map[it.trk][it.sec]) begin
                  trk_map[it.trk][it.sec] = 1'b1;
                  trk_cnt[it.trk] = trk_cnt[it.trk] + 1'b1;
               end
               r.status = ST_OK;
            end
         end
         REQ_READ: begin
            if (track_valid(it.trk)) begin
               r.cnt    = trk_cnt[it.trk];
               r.map    = trk_map[it.trk];
               r.status = ST_OK;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic bam_req_t mk_req(logic [REQ_W-1:0] kind, int t, int s, int c,
                                       logic [MAP_W-1:0] map);
      bam_req_t it;
      it.kind  = kind;
      it.trk   = TRK_W'(t);
      it.sec   = SEC_W'(s);
      it.cnt   = CNT_W'(c);
      it.map   = map;
      it.drain = 1'b0;
      return it;
   endfunction

   // Random item; odd rounds keep to the upper tracks so the search crosses the reserved one
   function automatic bam_req_t rand_req(int round);
      bam_req_t it;
      int       pick;
      int       mode;
      it.kind  = REQ_W'($urandom_range(0, 7));
      it.trk   = TRK_W'($urandom);
      it.sec   = SEC_W'($urandom);
      it.cnt   = CNT_W'($urandom);
      it.map   = {8'($urandom), 32'($urandom)};
      it.drain = ($urandom_range(0, 99) == 0);
      pick     = $urandom_range(0, 99);
      if (pick >= 5) begin
         // Valid kind and track with random content
         if (pick < 20)      it.kind = REQ_LOAD;
         else if (pick < 50) it.kind = REQ_NEAREST;
         else if (pick < 62) it.kind = REQ_ALLOC_TRK;
         else if (pick < 87) it.kind = REQ_FREE;
         else                it.kind = REQ_READ;
         if (round % 2 == 1) it.trk = TRK_W'($urandom_range(RESERVED_TRACK, NUM_TRACKS));
         else                it.trk = TRK_W'($urandom_range(1, NUM_TRACKS));
         if ($urandom_range(0, 9) != 0) it.sec = SEC_W'($urandom_range(0, SECTORS_PER_TRK - 1));
         mode = $urandom_range(0, 5);
         case (mode)
            0: it.map = it.map & {8'($urandom), 32'($urandom)} & {8'($urandom), 32'($urandom)};
            1: it.map = MAP_W'(1) << $urandom_range(0, MAP_W - 1);
            2: it.map = '1;
            3: it.map = '0;
            default: ;
         endcase
         mode = $urandom_range(0, 5);
         if (mode < 3)       it.cnt = CNT_W'($countones(it.map));
         else if (mode == 3) it.cnt = '0;
      end
      return it;
   endfunction

   task automatic check_field(string name, logic [MAP_W-1:0] want, logic [MAP_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         err_cnt++;
      end
   endtask

   // Drive items: predict on acceptance, hold while busy, send in bursts with idle gaps
   always @(posedge clock) begin : drive
      logic raise;
      logic idle;
      raise = 1'b0;
      idle  = !start && !busy && !rsp_valid && expected_rsps.size() == 0;
      if (reset) begin
         start <= 1'b0;
      end else if (start && busy) begin
         // hold the item until the block takes it
      end else begin
         if (start) expected_rsps.push_back(predict_alloc(cur_req));
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_reqs.size() > 0 && (!pending_reqs[0].drain || idle)) begin
            cur_req = pending_reqs.pop_front();
            req_type       <= cur_req.kind;
            req_track_num  <= cur_req.trk;
            req_sector_num <= cur_req.sec;
            req_count_in   <= cur_req.cnt;
            req_map_in     <= cur_req.map;
            raise = 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 15);
               if ($urandom_range(0, 3) == 0)      gap_left = 0;
               else if ($urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 90);
               else                                gap_left = $urandom_range(1, 6);
            end
         end
         start <= raise;
      end
   end

   // Compare each answer with the oldest prediction
   always @(posedge clock) begin : watch
      bam_rsp_t want;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $error("answer with no item outstanding: status %0d", rsp_status);
            err_cnt++;
         end else begin
            want = expected_rsps.pop_front();
            check_field("status", MAP_W'(want.status), MAP_W'(rsp_status));
            check_field("got_track", MAP_W'(want.trk), MAP_W'(rsp_got_track));
            check_field("got_sector", MAP_W'(want.sec), MAP_W'(rsp_got_sector));
            check_field("count_out", MAP_W'(want.cnt), MAP_W'(rsp_count_out));
            check_field("map_out", MAP_W'(want.map), MAP_W'(rsp_map_out));
         end
      end
   end

   // Build the item list, release reset, wait for the last answer
   initial begin : stimulus
      bam_req_t it;
      // Empty map after reset, bad tracks and unknown requests
      pending_reqs.push_back(mk_req(REQ_READ, 1, 0, 0, '0));
      pending_reqs.push_back(mk_req(REQ_NEAREST, 0, 0, 0, '0));
      pending_reqs.push_back(mk_req(REQ_LOAD, 0, 0, 255, '1));
      pending_reqs.push_back(mk_req(REQ_LOAD, 81, 0, 255, '1));
      pending_reqs.push_back(mk_req(REQ_READ, 127, 63, 255, '1));
      pending_reqs.push_back(mk_req(REQ_FREE, 0, 5, 0, '0));
      pending_reqs.push_back(mk_req(REQ_ALLOC_TRK, 127, 0, 0, '0));
      pending_reqs.push_back(mk_req(REQ_W'(5), 1, 0, 0, '0));
      pending_reqs.push_back(mk_req(REQ_W'(6), 1, 0, 0, '0));
      pending_reqs.push_back(mk_req(REQ_W'(7), 80, 39, 255, '1));
      // Full edge tracks, reserved track, and a zero count over a nonempty map
      pending_reqs.push_back(mk_req(REQ_LOAD, 1, 0, 255, '1));
      pending_reqs.push_back(mk_req(REQ_LOAD, 80, 0, 40, '1));
      pending_reqs.push_back(mk_req(REQ_LOAD, RESERVED_TRACK, 0, 1, 40'h80_0000_0000));
      pending_reqs.push_back(mk_req(REQ_LOAD, RESERVED_TRACK - 1, 0, 0, 40'h00_0000_00f0));
      pending_reqs.push_back(mk_req(REQ_NEAREST, 0, 0, 0, '0));
      pending_reqs.push_back(mk_req(REQ_ALLOC_TRK, RESERVED_TRACK, 0, 0, '0));
      pending_reqs.push_back(mk_req(REQ_ALLOC_TRK, RESERVED_TRACK, 0, 0, '0));
      // Nonzero count over an empty map, and a count that wraps on free
      pending_reqs.push_back(mk_req(REQ_LOAD, 5, 0, 5, '0));
      pending_reqs.push_back(mk_req(REQ_ALLOC_TRK, 5, 0, 0, '0));
      pending_reqs.push_back(mk_req(REQ_LOAD, 2, 0, 255, '0));
      pending_reqs.push_back(mk_req(REQ_FREE, 2, 3, 0, '0));
      // Free a taken sector twice, the top sector, and sectors past the end
      pending_reqs.push_back(mk_req(REQ_FREE, 1, 0, 0, '0));
      pending_reqs.push_back(mk_req(REQ_FREE, 1, 0, 0, '0));
      pending_reqs.push_back(mk_req(REQ_FREE, 80, 39, 0, '0));
      pending_reqs.push_back(mk_req(REQ_FREE, 80, 40, 0, '0));
      pending_reqs.push_back(mk_req(REQ_FREE, 80, 63, 0, '0));
      pending_reqs.push_back(mk_req(REQ_READ, 2, 0, 0, '0));
      pending_reqs.push_back(mk_req(REQ_READ, 80, 0, 0, '0));

      // Random rounds; odd rounds start by emptying the lower tracks
      for (int r = 0; r < RAND_ROUNDS; r++) begin
         if (r % 2 == 1) begin
            for (int t = 1; t < RESERVED_TRACK; t++) begin
               it = mk_req(REQ_LOAD, t, $urandom_range(0, 63), $urandom_range(0, 255), '0);
               it.drain = (t == 1);
               pending_reqs.push_back(it);
            end
         end
         for (int i = 0; i < ROUND_ITEMS; i++) begin
            it = rand_req(r);
            if (i == 0) it.drain = 1'b1;
            pending_reqs.push_back(it);
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Wait for the last item to be taken and answered
      @(negedge clock);
      while (pending_reqs.size() != 0 || start || busy || expected_rsps.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_rsps.size() != 0) begin
         $error("%0d answers missing", expected_rsps.size());
         err_cnt++;
      end
      if (err_cnt == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Stop a hung run
   initial begin : watchdog
      #20ms;
      $display("status: fail");
      $finish;
   end

endmodule
